@@ design/run_length_text_expander_top_defines.svh @@
// Assertion macros for the run-length text expander.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef RUN_LENGTH_TEXT_EXPANDER_TOP_DEFINES_SVH
`define RUN_LENGTH_TEXT_EXPANDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RLTE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlte check failed");

// Next-cycle implication, disabled during reset.
`define RLTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlte check failed");

`endif

@@ design/rlte_pkg.sv @@
// Shared types and constants for the run-length text expander.
// No dependencies; used by every module of the block.
`default_nettype none

package rlte_pkg;

    localparam int HEADER_BYTES = 40;
    localparam int HDR_W        = 6;

    localparam int CFG_W  = 12;
    localparam int ROW_W  = 13;
    localparam int CNT_W  = 8;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 9;

    localparam logic [CFG_W-1:0] MIN_WIDTH = 12'd5;
    localparam logic [ROW_W-1:0] ROW_MAX   = 13'd8191;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd5;
    localparam logic [CFG_W-1:0] TOTAL_ROWS_RST = 12'd5;

    // Configuration register indexes
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_TOTAL_ROWS = 1'b1;

    // Parse phases within a triple
    localparam logic [1:0] PH_SEP = 2'd0;
    localparam logic [1:0] PH_SYM = 2'd1;
    localparam logic [1:0] PH_CNT = 2'd2;

    // Command operations passed from front to back
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_SEP  = 2'd1;
    localparam logic [1:0] OP_RUN  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic             restart;
        logic [1:0]       op;
        logic [SYM_W-1:0] symbol;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic             break_before;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] segment_length;
        logic             last_of_run;
        logic             picture_done;
    } seg_t;

    typedef struct packed {
        logic             busy;
        logic [CFG_W-1:0] width_eff;
    } bk_stat_t;

endpackage

`default_nettype wire

@@ design/rlte_front.sv @@
// Front end: drops the header, tracks the triple phase and emits commands.
// Depends on rlte_pkg.
`default_nettype none

module rlte_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    file_start,
    input  wire logic                    q_full,
    output logic                         q_push,
    output rlte_pkg::cmd_t               q_data
);
    import rlte_pkg::*;

    logic [HDR_W-1:0] hdr_left_reg, hdr_left_next;
    logic [1:0]       phase_reg, phase_next;
    logic [SYM_W-1:0] sym_reg, sym_next;

    logic [HDR_W-1:0] hdr_cur;
    logic [1:0]       phase_cur;
    logic [SYM_W-1:0] sym_cur;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hdr_cur   = file_start ? HDR_W'(HEADER_BYTES) : hdr_left_reg;
        phase_cur = file_start ? PH_SEP : phase_reg;
        sym_cur   = file_start ? '0 : sym_reg;

        hdr_left_next = hdr_left_reg;
        phase_next    = phase_reg;
        sym_next      = sym_reg;

        q_data.restart = file_start;
        q_data.op      = OP_NONE;
        q_data.symbol  = sym_cur;
        q_data.count   = data_byte;

        if (accept)
        begin
            hdr_left_next = hdr_cur;
            phase_next    = phase_cur;
            sym_next      = sym_cur;
            if (hdr_cur != '0)
            begin
                hdr_left_next = hdr_cur - 1'b1;
            end
            else
            begin
                case (phase_cur)
                    PH_SYM:
                    begin
                        sym_next   = data_byte;
                        phase_next = PH_CNT;
                    end
                    PH_CNT:
                    begin
                        q_data.op  = OP_RUN;
                        phase_next = PH_SEP;
                    end
                    default:
                    begin
                        // separator; the row total check is done in the back end
                        q_data.op  = OP_SEP;
                        phase_next = PH_SYM;
                    end
                endcase
            end
        end
    end

    assign q_push = accept && (file_start || (q_data.op != OP_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_left_reg <= HDR_W'(HEADER_BYTES);
            phase_reg    <= PH_SEP;
            sym_reg      <= '0;
        end
        else
        begin
            hdr_left_reg <= hdr_left_next;
            phase_reg    <= phase_next;
            sym_reg      <= sym_next;
        end
    end

endmodule

`default_nettype wire

@@ design/rlte_queue.sv @@
// Short command queue between the front and back ends.
// Depends on rlte_pkg.
`default_nettype none

module rlte_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  rlte_pkg::cmd_t  push_data,
    input  wire logic       pop,
    output rlte_pkg::cmd_t  pop_data,
    output logic            full,
    output logic            empty
);
    import rlte_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/rlte_back.sv @@
// Back end: executes commands, splits runs into line segments, holds the raster position.
// Depends on rlte_pkg.
`default_nettype none

module rlte_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rlte_pkg::CFG_W-1:0]    line_width,
    input  wire logic [rlte_pkg::CFG_W-1:0]    total_rows,
    input  wire logic                          q_empty,
    input  rlte_pkg::cmd_t                     q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rlte_pkg::seg_t                     seg,
    output rlte_pkg::bk_stat_t                 stat
);
    import rlte_pkg::*;

    logic             busy_reg, busy_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic [CFG_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             any_reg, any_next;
    logic             fin_reg, fin_next;
    logic             oval_reg, oval_next;
    seg_t             seg_reg, seg_next;

    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] col0, col1, room;
    logic [ROW_W-1:0] row0, row1;
    logic [LEN_W-1:0] len, left1;
    logic             emit;
    logic             fin_eff;
    logic [ROW_W-1:0] row_eff;
    logic [ROW_W-1:0] total_ext;

    assign w         = (line_width < MIN_WIDTH) ? MIN_WIDTH : line_width;
    assign total_ext = {1'b0, total_rows};

    // Segment datapath: close a line left over from a wider width, take up to line end
    always_comb
    begin
        if (col_reg >= w)
        begin
            col0 = '0;
            row0 = (row_reg < ROW_MAX) ? row_reg + 1'b1 : row_reg;
        end
        else
        begin
            col0 = col_reg;
            row0 = row_reg;
        end
        room = w - col0;
        if ({1'b0, room} > {4'b0, left_reg})
            len = left_reg;
        else
            len = room[LEN_W-1:0];
        left1 = left_reg - len;
        col1  = col0 + {3'b0, len};
        row1  = row0;
        if (col1 >= w)
        begin
            col1 = '0;
            row1 = (row0 < ROW_MAX) ? row0 + 1'b1 : row0;
        end
    end

    assign emit  = busy_reg && (!oval_reg || out_ready);
    assign q_pop = !busy_reg && !q_empty;

    assign fin_eff = q_data.restart ? 1'b0 : fin_reg;
    assign row_eff = q_data.restart ? '0 : row_reg;

    always_comb
    begin
        busy_next = busy_reg;
        left_next = left_reg;
        sym_next  = sym_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        any_next  = any_reg;
        fin_next  = fin_reg;
        oval_next = oval_reg;
        seg_next  = seg_reg;

        if (oval_reg && out_ready)
            oval_next = 1'b0;

        if (q_pop)
        begin
            if (q_data.restart)
            begin
                col_next = '0;
                row_next = '0;
                any_next = 1'b0;
                fin_next = 1'b0;
            end
            if (!fin_eff)
            begin
                case (q_data.op)
                    OP_SEP:
                    begin
                        if (row_eff >= total_ext)
                            fin_next = 1'b1;
                    end
                    OP_RUN:
                    begin
                        busy_next = 1'b1;
                        left_next = {1'b0, q_data.count} + 1'b1;
                        sym_next  = q_data.symbol;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (emit)
        begin
            oval_next               = 1'b1;
            seg_next.break_before   = (col0 == '0) && any_reg;
            seg_next.symbol         = sym_reg;
            seg_next.segment_length = len;
            seg_next.last_of_run    = (left1 == '0);
            seg_next.picture_done   = (row1 >= total_ext);
            col_next  = col1;
            row_next  = row1;
            left_next = left1;
            any_next  = 1'b1;
            if (left1 == '0)
            begin
                busy_next = 1'b0;
                if (row1 >= total_ext)
                    fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            any_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            any_reg  <= any_next;
            fin_reg  <= fin_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        sym_reg  <= sym_next;
        seg_reg  <= seg_next;
    end

    assign out_valid      = oval_reg;
    assign seg            = seg_reg;
    assign stat.busy      = busy_reg;
    assign stat.width_eff = w;

endmodule

`default_nettype wire

@@ design/run_length_text_expander_top.sv @@
// Run-length text expander, top level; depends on rlte_pkg, rlte_front,
// rlte_queue, rlte_back and the assertion macro header.
//
// Input channel (in_valid/in_ready): one raw file byte per transfer, with
// file_start marking header byte zero of a new file. The first 40 bytes are
// dropped, then bytes form triples of separator, symbol and count.
// Output channel (out_valid/out_ready): one text segment per transfer: an
// optional newline, then symbol repeated segment_length times.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 line width, index 1 row
// total; write only while the block is idle.
// Rate: header, separator and symbol bytes are accepted while the queue is
// not full. A count byte becomes a run command; the back end loads a run
// only when idle, then emits one segment per cycle while the receiver is
// ready. The single segment unit sets the rate.
// A four-entry command queue lets bytes keep arriving while a run expands.
// Reset restores both config registers to 5 and restarts parsing. When the
// receiver stalls, the segment holds in the output register, the back end
// stops, and in_ready drops once the queue fills.
`default_nettype none
`include "run_length_text_expander_top_defines.svh"

module run_length_text_expander_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        file_start,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             break_before,
    output logic [7:0]                       symbol,
    output logic [8:0]                       segment_length,
    output logic                             last_of_run,
    output logic                             picture_done,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [rlte_pkg::CFG_W-1:0]  cfg_wdata
);
    import rlte_pkg::*;

    logic [CFG_W-1:0] line_width_reg, total_rows_reg;

    cmd_t     push_data, pop_data;
    logic     q_push, q_pop, q_full, q_empty;
    seg_t     seg;
    bk_stat_t bk_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RST;
            total_rows_reg <= TOTAL_ROWS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_WIDTH: line_width_reg <= cfg_wdata;
                REG_TOTAL_ROWS: total_rows_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    rlte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .file_start (file_start),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    rlte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    rlte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_width (line_width_reg),
        .total_rows (total_rows_reg),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .seg        (seg),
        .stat       (bk_stat)
    );

    assign break_before   = seg.break_before;
    assign symbol         = seg.symbol;
    assign segment_length = seg.segment_length;
    assign last_of_run    = seg.last_of_run;
    assign picture_done   = seg.picture_done;

    `RLTE_ASSERT_SAME(a_len_nonzero, out_valid, segment_length != '0)
    `RLTE_ASSERT_SAME(a_len_fits_line, out_valid, CFG_W'(segment_length) <= bk_stat.width_eff)
    `RLTE_ASSERT_SAME(a_pop_when_idle, q_pop, !bk_stat.busy && !q_empty)
    `RLTE_ASSERT_NEXT(a_run_load_busy, q_pop && pop_data.restart && (pop_data.op == OP_RUN), bk_stat.busy)

endmodule

`default_nettype wire
